@@ hw/rtl/rom_pkg.sv @@
`timescale 1ns / 1ps
package rom_pkg;

    typedef enum logic [1:0] {
        FUNC_SUBMIT = 2'd0,
        FUNC_CANCEL = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_QUERY  = 2'd3
    } func_t;

    localparam logic [3:0] CODE_DONE      = 4'd0;
    localparam logic [3:0] CODE_IGNORED   = 4'd1;
    localparam logic [3:0] CODE_INVALID   = 4'd2;
    localparam logic [3:0] CODE_CONFLICT  = 4'd3;
    localparam logic [3:0] CODE_BACKDATED = 4'd4;
    localparam logic [3:0] CODE_FULL      = 4'd5;
    localparam logic [3:0] CODE_UNKNOWN   = 4'd6;
    localparam logic [3:0] CODE_BAD_TICK  = 4'd7;
    localparam logic [3:0] CODE_EXHAUSTED = 4'd8;

    localparam logic [1:0] ST_WORKING   = 2'd0;
    localparam logic [1:0] ST_FILLED    = 2'd1;
    localparam logic [1:0] ST_CANCELLED = 2'd2;
    localparam logic [1:0] ST_EXPIRED   = 2'd3;

    localparam logic [1:0] TIF_RESTING = 2'd0;
    localparam logic [1:0] TIF_FOK     = 2'd2;
    localparam logic [1:0] TIF_BAD     = 2'd3;

    localparam logic [29:0] QTY_MAX = 30'd1000000000;

    localparam logic CFG_INSTRUMENT = 1'b0;
    localparam logic CFG_LIMIT      = 1'b1;

    // One stored order.
    typedef struct packed {
        logic [31:0] id;
        logic        side;
        logic [1:0]  tif;
        logic [29:0] qty;
        logic [31:0] limit;
        logic [47:0] t_sub;
        logic [47:0] t_exp;
        logic [29:0] filled;
        logic [1:0]  status;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
    } stat_t;

endpackage

@@ hw/rtl/rom_ctrl.sv @@
`timescale 1ns / 1ps
module rom_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rom_pkg::stat_t stat,
    output rom_pkg::cmd_t  cmd
);
    import rom_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WALK   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.step = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/rom_datapath.sv @@
`timescale 1ns / 1ps
module rom_datapath
#(
    parameter int ORDER_SLOTS = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  rom_pkg::cmd_t  cmd,
    output rom_pkg::stat_t stat,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_data,
    input  logic [1:0]     func,
    input  logic [31:0]    order_id,
    input  logic [15:0]    instrument,
    input  logic           side,
    input  logic [1:0]     time_in_force,
    input  logic [29:0]    quantity,
    input  logic [31:0]    price,
    input  logic [47:0]    time_us,
    input  logic [47:0]    expires_us,
    input  logic [31:0]    trading_day,
    input  logic [47:0]    cumulative_volume,
    output logic           result_strobe,
    output logic [3:0]     code,
    output logic [31:0]    result_order_id,
    output logic [1:0]     order_status,
    output logic [29:0]    filled_total,
    output logic [29:0]    fill_quantity,
    output logic [31:0]    fill_price,
    output logic [47:0]    fill_time_us,
    output logic [63:0]    fill_sequence,
    output logic           last
);
    import rom_pkg::*;

    localparam int IDX_W = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int CNT_W = $clog2(ORDER_SLOTS + 1);

    // Order memory, one read and one write port, registered read.
    entry_t mem [ORDER_SLOTS];
    entry_t mem_q_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    // Configuration.
    logic [15:0] inst_code_reg;
    logic [6:0]  order_limit_reg;

    // Table and tick state.
    logic [CNT_W-1:0] count_reg;
    logic [47:0] ltt_reg;
    logic [31:0] ltp_reg;
    logic [31:0] ltd_reg;
    logic [47:0] ltv_reg;
    logic        seen_reg;
    logic [63:0] seq_reg;

    // Latched beat.
    logic [1:0]  in_func_reg;
    logic [31:0] in_id_reg;
    logic [15:0] in_inst_reg;
    logic        in_side_reg;
    logic [1:0]  in_tif_reg;
    logic [29:0] in_qty_reg;
    logic [31:0] in_price_reg;
    logic [47:0] in_t_reg;
    logic [47:0] in_ex_reg;
    logic [31:0] in_day_reg;
    logic [47:0] in_cum_reg;
    logic [47:0] vol_reg;

    // Walk.
    logic [CNT_W-1:0] rd_idx_reg;
    logic             ev_vld_reg;
    logic [IDX_W-1:0] ev_idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] fidx_reg;
    entry_t           fent_reg;

    // Fill held back until the next one shows whether it is the final one.
    logic        hold_vld_reg;
    logic [31:0] hold_id_reg;
    logic [1:0]  hold_st_reg;
    logic [29:0] hold_filled_reg;
    logic [29:0] hold_amt_reg;

    // Output register.
    logic        o_fire;
    logic [3:0]  o_code;
    logic [31:0] o_id;
    logic [1:0]  o_st;
    logic [29:0] o_tot;
    logic [29:0] o_fq;
    logic [31:0] o_fp;
    logic [47:0] o_ft;
    logic [63:0] o_seq;
    logic        o_last;
    logic        strobe_reg;
    logic [3:0]  code_reg;
    logic [31:0] id_reg;
    logic [1:0]  st_reg;
    logic [29:0] tot_reg;
    logic [29:0] fq_reg;
    logic [31:0] fp_reg;
    logic [47:0] ft_reg;
    logic [63:0] oseq_reg;
    logic        last_reg;

    // Tick classification.
    logic        is_tick;
    logic        tick_bad;
    logic        tick_rep;
    logic        tick_exh;
    logic        tick_go;
    logic        walk_en;
    logic        rd_more;
    logic [63:0] seq_inc;

    // Entry evaluation.
    entry_t      e;
    logic        e_active;
    logic        e_expire;
    logic        e_live;
    logic        e_crossed;
    logic [29:0] e_left;
    logic        e_vol_lt;
    logic [29:0] e_amount;
    logic [29:0] e_new_filled;
    logic [1:0]  e_new_status;
    logic        e_emit;
    logic        ev_tick;
    logic        ev_search;

    // Finish.
    logic        sub_invalid;
    logic        sub_same;
    logic        sub_back;
    logic        sub_full;
    logic [6:0]  eff_limit;
    entry_t      new_entry;
    entry_t      cancel_entry;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    assign is_tick  = (in_func_reg == FUNC_TICK);
    assign tick_bad = (in_price_reg == 32'd0) || (in_t_reg == 48'd0) ||
                      (in_inst_reg != inst_code_reg) ||
                      (seen_reg && ((in_t_reg < ltt_reg) || (in_day_reg < ltd_reg) ||
                       ((in_day_reg == ltd_reg) && (in_cum_reg < ltv_reg))));
    assign tick_rep = seen_reg && (in_t_reg == ltt_reg) && (in_price_reg == ltp_reg) &&
                      (in_day_reg == ltd_reg) && (in_cum_reg == ltv_reg);
    assign tick_exh = (seq_reg == {64{1'b1}});
    assign tick_go  = !tick_bad && !tick_rep && !tick_exh;
    assign walk_en  = is_tick ? tick_go : 1'b1;
    assign seq_inc  = seq_reg + 64'd1;

    assign rd_more   = walk_en && !found_reg && (rd_idx_reg < count_reg);
    assign mem_re    = cmd.step && rd_more;
    assign mem_raddr = rd_idx_reg[IDX_W-1:0];
    assign stat.walk_done = !ev_vld_reg && !rd_more;

    assign e         = mem_q_reg;
    assign e_active  = (e.status == ST_WORKING);
    assign e_expire  = (in_t_reg >= e.t_exp);
    assign e_live    = (in_t_reg > e.t_sub);
    assign e_crossed = e.side ? (in_price_reg >= e.limit) : (in_price_reg <= e.limit);
    assign e_left    = (e.qty > e.filled) ? (e.qty - e.filled) : 30'd0;
    assign e_vol_lt  = (vol_reg < {18'd0, e_left});
    assign e_amount  = (!e_crossed || ((e.tif == TIF_FOK) && e_vol_lt)) ? 30'd0 :
                       (e_vol_lt ? vol_reg[29:0] : e_left);
    assign e_new_filled = e.filled + e_amount;
    assign e_new_status = (e_new_filled == e.qty) ? ST_FILLED :
                          ((e.tif != TIF_RESTING) ? ST_CANCELLED : ST_WORKING);
    assign ev_tick   = cmd.step && ev_vld_reg && is_tick;
    assign ev_search = cmd.step && ev_vld_reg && !is_tick;
    assign e_emit    = ev_tick && e_active && !e_expire && e_live && (e_amount != 30'd0);

    assign sub_invalid = (in_inst_reg != inst_code_reg) || (in_tif_reg == TIF_BAD) ||
                         (in_qty_reg == 30'd0) || (in_qty_reg > QTY_MAX) ||
                         (in_price_reg == 32'd0) || (in_t_reg == 48'd0) ||
                         (in_ex_reg <= in_t_reg);
    assign sub_same = (fent_reg.side == in_side_reg) && (fent_reg.tif == in_tif_reg) &&
                      (fent_reg.qty == in_qty_reg) && (fent_reg.limit == in_price_reg) &&
                      (fent_reg.t_sub == in_t_reg) && (fent_reg.t_exp == in_ex_reg);
    assign sub_back = seen_reg && (in_t_reg < ltt_reg);
    assign eff_limit = (order_limit_reg == 7'd0) ? 7'd1 :
                       ((order_limit_reg > 7'(ORDER_SLOTS)) ? 7'(ORDER_SLOTS) :
                        order_limit_reg);
    assign sub_full = (7'(count_reg) >= eff_limit);

    always_comb
    begin
        new_entry        = '0;
        new_entry.id     = in_id_reg;
        new_entry.side   = in_side_reg;
        new_entry.tif    = in_tif_reg;
        new_entry.qty    = in_qty_reg;
        new_entry.limit  = in_price_reg;
        new_entry.t_sub  = in_t_reg;
        new_entry.t_exp  = in_ex_reg;
        new_entry.filled = 30'd0;
        new_entry.status = ST_WORKING;
        cancel_entry        = fent_reg;
        cancel_entry.status = ST_CANCELLED;
    end

    // Memory write and result selection.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ev_idx_reg;
        mem_wdata = e;
        o_fire    = 1'b0;
        o_code    = CODE_DONE;
        o_id      = 32'd0;
        o_st      = ST_WORKING;
        o_tot     = 30'd0;
        o_fq      = 30'd0;
        o_fp      = 32'd0;
        o_ft      = 48'd0;
        o_seq     = 64'd0;
        o_last    = 1'b1;

        if (ev_tick && e_active && (e_expire || e_live))
        begin
            mem_we = 1'b1;
            if (e_expire)
            begin
                mem_wdata.status = ST_EXPIRED;
            end
            else
            begin
                mem_wdata.filled = e_new_filled;
                mem_wdata.status = e_new_status;
            end
        end

        // A new fill releases the one held before it.
        if (e_emit && hold_vld_reg)
        begin
            o_fire = 1'b1;
            o_id   = hold_id_reg;
            o_st   = hold_st_reg;
            o_tot  = hold_filled_reg;
            o_fq   = hold_amt_reg;
            o_fp   = in_price_reg;
            o_ft   = in_t_reg;
            o_seq  = seq_inc;
            o_last = 1'b0;
        end

        if (cmd.finish)
        begin
            o_fire = 1'b1;
            o_id   = in_id_reg;
            case (in_func_reg)
                FUNC_TICK:
                begin
                    o_id = 32'd0;
                    if (tick_bad)
                    begin
                        o_code = CODE_BAD_TICK;
                    end
                    else if (tick_rep)
                    begin
                        o_code = CODE_IGNORED;
                    end
                    else if (tick_exh)
                    begin
                        o_code = CODE_EXHAUSTED;
                    end
                    else
                    begin
                        o_seq = seq_inc;
                        if (hold_vld_reg)
                        begin
                            o_id  = hold_id_reg;
                            o_st  = hold_st_reg;
                            o_tot = hold_filled_reg;
                            o_fq  = hold_amt_reg;
                            o_fp  = in_price_reg;
                            o_ft  = in_t_reg;
                        end
                    end
                end
                FUNC_SUBMIT:
                begin
                    if (sub_invalid)
                    begin
                        o_code = CODE_INVALID;
                    end
                    else if (found_reg)
                    begin
                        o_code = sub_same ? CODE_IGNORED : CODE_CONFLICT;
                        o_st   = fent_reg.status;
                        o_tot  = fent_reg.filled;
                    end
                    else if (sub_back)
                    begin
                        o_code = CODE_BACKDATED;
                    end
                    else if (sub_full)
                    begin
                        o_code = CODE_FULL;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = count_reg[IDX_W-1:0];
                        mem_wdata = new_entry;
                    end
                end
                default:
                begin
                    if (!found_reg)
                    begin
                        o_code = CODE_UNKNOWN;
                    end
                    else
                    begin
                        o_st  = fent_reg.status;
                        o_tot = fent_reg.filled;
                        if (in_func_reg == FUNC_CANCEL)
                        begin
                            if (fent_reg.status != ST_WORKING)
                            begin
                                o_code = CODE_IGNORED;
                            end
                            else
                            begin
                                o_st      = ST_CANCELLED;
                                mem_we    = 1'b1;
                                mem_waddr = fidx_reg;
                                mem_wdata = cancel_entry;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inst_code_reg   <= 16'd0;
            order_limit_reg <= 7'd64;
            count_reg       <= '0;
            ltt_reg         <= 48'd0;
            ltp_reg         <= 32'd0;
            ltd_reg         <= 32'd0;
            ltv_reg         <= 48'd0;
            seen_reg        <= 1'b0;
            seq_reg         <= 64'd0;
            rd_idx_reg      <= '0;
            ev_vld_reg      <= 1'b0;
            found_reg       <= 1'b0;
            hold_vld_reg    <= 1'b0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg <= o_fire;
            if (cfg_we)
            begin
                if (cfg_index == CFG_INSTRUMENT)
                begin
                    inst_code_reg <= cfg_data;
                end
                else
                begin
                    order_limit_reg <= cfg_data[6:0];
                end
            end
            if (cmd.capture)
            begin
                rd_idx_reg   <= '0;
                ev_vld_reg   <= 1'b0;
                found_reg    <= 1'b0;
                hold_vld_reg <= 1'b0;
            end
            if (cmd.step)
            begin
                ev_vld_reg <= rd_more;
                if (rd_more)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
            end
            if (ev_search && !found_reg && (e.id == in_id_reg))
            begin
                found_reg <= 1'b1;
            end
            if (e_emit)
            begin
                hold_vld_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                if (is_tick && tick_go)
                begin
                    ltt_reg  <= in_t_reg;
                    ltp_reg  <= in_price_reg;
                    ltd_reg  <= in_day_reg;
                    ltv_reg  <= in_cum_reg;
                    seen_reg <= 1'b1;
                    seq_reg  <= seq_inc;
                end
                if ((in_func_reg == FUNC_SUBMIT) && !sub_invalid && !found_reg &&
                    !sub_back && !sub_full)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_func_reg  <= func;
            in_id_reg    <= order_id;
            in_inst_reg  <= instrument;
            in_side_reg  <= side;
            in_tif_reg   <= time_in_force;
            in_qty_reg   <= quantity;
            in_price_reg <= price;
            in_t_reg     <= time_us;
            in_ex_reg    <= expires_us;
            in_day_reg   <= trading_day;
            in_cum_reg   <= cumulative_volume;
            vol_reg      <= (seen_reg && (trading_day == ltd_reg)) ?
                            (cumulative_volume - ltv_reg) : 48'd0;
        end
        if (cmd.step)
        begin
            ev_idx_reg <= mem_raddr;
        end
        if (ev_search && !found_reg && (e.id == in_id_reg))
        begin
            fidx_reg <= ev_idx_reg;
            fent_reg <= e;
        end
        if (ev_tick && e_active && !e_expire && e_live)
        begin
            vol_reg <= vol_reg - {18'd0, e_amount};
        end
        if (e_emit)
        begin
            hold_id_reg     <= e.id;
            hold_st_reg     <= e_new_status;
            hold_filled_reg <= e_new_filled;
            hold_amt_reg    <= e_amount;
        end
        if (o_fire)
        begin
            code_reg <= o_code;
            id_reg   <= o_id;
            st_reg   <= o_st;
            tot_reg  <= o_tot;
            fq_reg   <= o_fq;
            fp_reg   <= o_fp;
            ft_reg   <= o_ft;
            oseq_reg <= o_seq;
            last_reg <= o_last;
        end
    end

    assign result_strobe   = strobe_reg;
    assign code            = code_reg;
    assign result_order_id = id_reg;
    assign order_status    = st_reg;
    assign filled_total    = tot_reg;
    assign fill_quantity   = fq_reg;
    assign fill_price      = fp_reg;
    assign fill_time_us    = ft_reg;
    assign fill_sequence   = oseq_reg;
    assign last            = last_reg;

endmodule

@@ hw/rtl/replay_order_matcher.sv @@
`timescale 1ns / 1ps
// Order table that simulates limit-order fills from replayed market ticks.
// A command beat is taken at a rising edge where start is high and busy is
// low; func selects submit, cancel, tick or query, and the other input ports
// carry its fields. While busy is high no new beat is taken.
// Every command walks the stored orders in arrival order, one entry per
// cycle through the order memory: submit, cancel and query look up the id
// and stop shortly after a hit, a tick updates each live order. The table
// holds up to ORDER_SLOTS orders; busy stays high for the whole walk and the
// final result beat is presented in the first cycle with busy low. A rejected
// tick or a command on an empty table reads no entries.
// Results appear one per cycle with result_strobe high for exactly one cycle;
// the receiver cannot hold them off. A tick gives one result beat per fill,
// and last marks the final result beat of every command.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the instrument
// code (index 0) or the order limit (index 1) at once; write it only while
// the block is idle. Reset empties the order table, clears the tick history
// and sets the instrument code to 0 and the order limit to 64. No memory
// clearing pass is needed: only entries below the stored-order count are read.
module replay_order_matcher
#(
    parameter int ORDER_SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  func,
    input  logic [31:0] order_id,
    input  logic [15:0] instrument,
    input  logic        side,
    input  logic [1:0]  time_in_force,
    input  logic [29:0] quantity,
    input  logic [31:0] price,
    input  logic [47:0] time_us,
    input  logic [47:0] expires_us,
    input  logic [31:0] trading_day,
    input  logic [47:0] cumulative_volume,
    output logic        result_strobe,
    output logic [3:0]  code,
    output logic [31:0] result_order_id,
    output logic [1:0]  order_status,
    output logic [29:0] filled_total,
    output logic [29:0] fill_quantity,
    output logic [31:0] fill_price,
    output logic [47:0] fill_time_us,
    output logic [63:0] fill_sequence,
    output logic        last
);
    import rom_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The controller sequences capture, the walk and the final result.
    rom_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // The datapath holds the order memory, tick history and result register.
    rom_datapath
    #(
        .ORDER_SLOTS (ORDER_SLOTS)
    )
    u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .func              (func),
        .order_id          (order_id),
        .instrument        (instrument),
        .side              (side),
        .time_in_force     (time_in_force),
        .quantity          (quantity),
        .price             (price),
        .time_us           (time_us),
        .expires_us        (expires_us),
        .trading_day       (trading_day),
        .cumulative_volume (cumulative_volume),
        .result_strobe     (result_strobe),
        .code              (code),
        .result_order_id   (result_order_id),
        .order_status      (order_status),
        .filled_total      (filled_total),
        .fill_quantity     (fill_quantity),
        .fill_price        (fill_price),
        .fill_time_us      (fill_time_us),
        .fill_sequence     (fill_sequence),
        .last              (last)
    );

endmodule
